// File: hdl/lpr_pkg.sv
package lpr_pkg;

    localparam int IN_PAGE_W = 16;
    localparam int CFG_W     = 5;
    localparam int OUT_W     = 40;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic [15:0]      FAULT_MAX = 16'hFFFF;

    typedef struct packed {
        logic vld;
        logic hit_f;
        logic emp_f;
    } t_tok_flg;

    typedef struct packed {
        logic en;
        logic clr;
        logic age_all;
        logic wr;
    } t_upd_ctl;

endpackage

// File: hdl/lpr_cell.sv
module lpr_cell
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0,
    parameter int RW        = 4,
    parameter int MW        = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [MW-1:0]        i_m,
    input  logic [PAGE_BITS-1:0] i_page,
    input  t_tok_flg             i_tok_flg,
    input  logic [RW-1:0]        i_tok_hit_idx,
    input  logic [RW-1:0]        i_tok_hit_rank,
    input  logic [RW-1:0]        i_tok_emp_idx,
    input  logic [RW-1:0]        i_tok_old_rank,
    input  logic [RW-1:0]        i_tok_old_idx,
    input  logic [PAGE_BITS-1:0] i_tok_old_page,
    output t_tok_flg             o_tok_flg,
    output logic [RW-1:0]        o_tok_hit_idx,
    output logic [RW-1:0]        o_tok_hit_rank,
    output logic [RW-1:0]        o_tok_emp_idx,
    output logic [RW-1:0]        o_tok_old_rank,
    output logic [RW-1:0]        o_tok_old_idx,
    output logic [PAGE_BITS-1:0] o_tok_old_page,
    input  t_upd_ctl             i_upd,
    input  logic [RW-1:0]        i_upd_slot,
    input  logic [RW-1:0]        i_upd_rank
);

    localparam logic [RW-1:0] MY_IDX   = RW'(IDX);
    localparam logic [MW-1:0] MY_M     = MW'(IDX);
    localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);
    localparam bit            FIRST    = (IDX == 0);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RW-1:0]        r_rank;

    logic                 in_use;
    logic                 mine;

    t_tok_flg             n_flg;
    logic [RW-1:0]        n_hit_idx, n_hit_rank, n_emp_idx, n_old_rank, n_old_idx;
    logic [PAGE_BITS-1:0] n_old_page;

    t_tok_flg             r_flg;
    logic [RW-1:0]        r_hit_idx, r_hit_rank, r_emp_idx, r_old_rank, r_old_idx;
    logic [PAGE_BITS-1:0] r_old_page;

    assign in_use = (MY_M < i_m);
    assign mine   = (i_upd_slot == MY_IDX);

    always_comb begin
        n_flg      = i_tok_flg;
        n_hit_idx  = i_tok_hit_idx;
        n_hit_rank = i_tok_hit_rank;
        n_emp_idx  = i_tok_emp_idx;
        n_old_rank = i_tok_old_rank;
        n_old_idx  = i_tok_old_idx;
        n_old_page = i_tok_old_page;
        if (in_use && r_valid && (r_page == i_page) && !i_tok_flg.hit_f) begin
            n_flg.hit_f = 1'b1;
            n_hit_idx   = MY_IDX;
            n_hit_rank  = r_rank;
        end
        if (in_use && !r_valid && !i_tok_flg.emp_f) begin
            n_flg.emp_f = 1'b1;
            n_emp_idx   = MY_IDX;
        end
        if (in_use && (FIRST || (r_rank > i_tok_old_rank))) begin
            n_old_rank = r_rank;
            n_old_idx  = MY_IDX;
            n_old_page = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg <= '0;
        end else begin
            r_flg <= n_flg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_emp_idx  <= n_emp_idx;
        r_old_rank <= n_old_rank;
        r_old_idx  <= n_old_idx;
        r_old_page <= n_old_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.clr) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (mine) begin
                r_rank <= '0;
                if (i_upd.wr) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid && (i_upd.age_all || (r_rank < i_upd_rank)) &&
                         (r_rank != RANK_MAX)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && !i_upd.clr && i_upd.wr && mine) begin
            r_page <= i_page;
        end
    end

    assign o_tok_flg      = r_flg;
    assign o_tok_hit_idx  = r_hit_idx;
    assign o_tok_hit_rank = r_hit_rank;
    assign o_tok_emp_idx  = r_emp_idx;
    assign o_tok_old_rank = r_old_rank;
    assign o_tok_old_idx  = r_old_idx;
    assign o_tok_old_page = r_old_page;

endmodule

// File: hdl/lru_page_replacement.sv
// A new reference is accepted only once the previous one has been fully processed; a
// lookup token walks the row of frame cells one cell per cycle, then the update is
// applied when the output register is free to take the result.
// Reset (synchronous, active low) empties all frames, zeroes ranks and the
// fault count, and sets frames_in_use to 16. A reference with tlast set
// clears the table and the count after its result is loaded.
module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_W-1:0]     i_cfg_wdata,     // frames_in_use
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_PAGE_W-1:0] i_s_axis_tdata,  // [15:0] page
    input  logic                 i_s_axis_tlast,  // last_reference
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] hit, [4:1] slot, [5] evicted_valid, [21:6] evicted_page,
    // [37:22] fault_total, [39:38] zero
    output logic [OUT_W-1:0]     o_m_axis_tdata
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int MW = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [PAGE_BITS-1:0] r_page;
    logic [MW-1:0]        r_m;
    logic                 r_last;
    logic                 r_launch;
    logic [15:0]          r_fault;
    logic                 r_ovalid;
    logic [OUT_W-1:0]     r_odata;

    logic                 r_hit;
    logic                 r_emp;
    logic [RW-1:0]        r_slot;
    logic [RW-1:0]        r_urank;
    logic [PAGE_BITS-1:0] r_evpage;

    logic [MW-1:0]        m_clamped;
    logic [31:0]          in_wide;
    logic                 accept;
    logic                 go;
    logic [15:0]          n_fault;
    logic [31:0]          slot_wide;
    logic [31:0]          ev_wide;
    logic [15:0]          ev_out;
    logic                 evict;
    t_upd_ctl             upd;

    t_tok_flg             tok_flg  [FRAMES+1];
    logic [RW-1:0]        tok_hidx [FRAMES+1];
    logic [RW-1:0]        tok_hrnk [FRAMES+1];
    logic [RW-1:0]        tok_eidx [FRAMES+1];
    logic [RW-1:0]        tok_orank[FRAMES+1];
    logic [RW-1:0]        tok_oidx [FRAMES+1];
    logic [PAGE_BITS-1:0] tok_opage[FRAMES+1];

    always_comb begin
        if (r_cfg == '0) begin
            m_clamped = MW'(1);
        end else if (32'(r_cfg) > FRAMES) begin
            m_clamped = MW'(FRAMES);
        end else begin
            m_clamped = MW'(r_cfg);
        end
    end

    assign in_wide = 32'(i_s_axis_tdata);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign go      = (r_state == S_UPD) && (!r_ovalid || i_m_axis_tready);
    assign evict   = !r_hit && !r_emp;

    assign n_fault   = r_hit ? r_fault :
                       ((r_fault == FAULT_MAX) ? r_fault : r_fault + 16'd1);
    assign slot_wide = 32'(r_slot);
    assign ev_wide   = 32'(r_evpage);
    assign ev_out    = evict ? ev_wide[15:0] : 16'd0;

    always_comb begin
        upd         = '0;
        upd.en      = go;
        upd.clr     = go && r_last;
        upd.age_all = r_emp && !r_hit;
        upd.wr      = !r_hit;
    end

    assign tok_flg[0]   = '{vld: r_launch, hit_f: 1'b0, emp_f: 1'b0};
    assign tok_hidx[0]  = '0;
    assign tok_hrnk[0]  = '0;
    assign tok_eidx[0]  = '0;
    assign tok_orank[0] = '0;
    assign tok_oidx[0]  = '0;
    assign tok_opage[0] = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lpr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g),
            .RW        (RW),
            .MW        (MW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_m            (r_m),
            .i_page         (r_page),
            .i_tok_flg      (tok_flg[g]),
            .i_tok_hit_idx  (tok_hidx[g]),
            .i_tok_hit_rank (tok_hrnk[g]),
            .i_tok_emp_idx  (tok_eidx[g]),
            .i_tok_old_rank (tok_orank[g]),
            .i_tok_old_idx  (tok_oidx[g]),
            .i_tok_old_page (tok_opage[g]),
            .o_tok_flg      (tok_flg[g+1]),
            .o_tok_hit_idx  (tok_hidx[g+1]),
            .o_tok_hit_rank (tok_hrnk[g+1]),
            .o_tok_emp_idx  (tok_eidx[g+1]),
            .o_tok_old_rank (tok_orank[g+1]),
            .o_tok_old_idx  (tok_oidx[g+1]),
            .o_tok_old_page (tok_opage[g+1]),
            .i_upd          (upd),
            .i_upd_slot     (r_slot),
            .i_upd_rank     (r_urank)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wen) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_fault  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_launch <= accept;
            if (go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok_flg[FRAMES].vld) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (go) begin
                        r_odata  <= {2'b00, n_fault, ev_out, evict,
                                     slot_wide[3:0], r_hit};
                        r_fault  <= r_last ? 16'd0 : n_fault;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= in_wide[PAGE_BITS-1:0];
            r_last <= i_s_axis_tlast;
            r_m    <= m_clamped;
        end
        if ((r_state == S_SCAN) && tok_flg[FRAMES].vld) begin
            r_hit    <= tok_flg[FRAMES].hit_f;
            r_emp    <= tok_flg[FRAMES].emp_f;
            r_evpage <= tok_opage[FRAMES];
            if (tok_flg[FRAMES].hit_f) begin
                r_slot  <= tok_hidx[FRAMES];
                r_urank <= tok_hrnk[FRAMES];
            end else if (tok_flg[FRAMES].emp_f) begin
                r_slot  <= tok_eidx[FRAMES];
                r_urank <= tok_orank[FRAMES];
            end else begin
                r_slot  <= tok_oidx[FRAMES];
                r_urank <= tok_orank[FRAMES];
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_tok_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_flg[FRAMES].vld |-> (r_state == S_SCAN))
        else $error("lookup token left the row outside a scan");

    a_hit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_flg[FRAMES].vld && tok_flg[FRAMES].hit_f) |->
            (32'(tok_hidx[FRAMES]) < 32'(r_m)))
        else $error("hit reported in a frame outside the in-use set");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) && o_m_axis_tdata[5] |-> !o_m_axis_tdata[0])
        else $error("eviction reported on a hit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_last) |=> (r_fault == 16'd0))
        else $error("fault count not cleared after last reference");

endmodule

// File: test/tb.sv
module tb;
    import lpr_pkg::*;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 20;

    typedef struct packed {
        logic [15:0] faults;
        logic [15:0] ev_page;
        logic        ev;
        logic [3:0]  slot;
        logic        hit;
    } t_lru_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic [IN_PAGE_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    logic [15:0]      res_page [16];
    logic             res_valid [16];
    logic [3:0]       res_rank [16];
    logic [15:0]      fault_cnt;
    logic [CFG_W-1:0] frames_cfg = CFG_RESET;
    t_lru_outcome     ref_outcomes [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  rx_hold = 0;
    int  rx_gap = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;

    lru_page_replacement uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [15:0] page
        .i_s_axis_tlast  (s_tlast),          // last_reference
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        // [0] hit, [4:1] slot, [5] evicted_valid, [21:6] evicted_page,
        // [37:22] fault_total, [39:38] zero
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic void clear_frames();
        for (int j = 0; j < 16; j++) begin
            res_page[j] = '0;
            res_valid[j] = 1'b0;
            res_rank[j] = '0;
        end
        fault_cnt = '0;
    endfunction

    function automatic t_lru_outcome lru_reference(input logic [15:0] page, input logic last);
        t_lru_outcome r;
        int           m;
        logic         found;
        logic [4:0]   age_lim;
        r = '0;
        found = 1'b0;
        age_lim = '0;
        m = (frames_cfg == 0) ? 1 : ((frames_cfg > 16) ? 16 : int'(frames_cfg));
        for (int j = 0; j < m; j++) begin
            if (!found && res_valid[j] && res_page[j] == page) begin
                found = 1'b1;
                r.slot = j[3:0];
            end
        end
        if (found) begin
            r.hit = 1'b1;
            age_lim = {1'b0, res_rank[r.slot]};
        end else begin
            for (int j = 0; j < m; j++) begin
                if (!found && !res_valid[j]) begin
                    found = 1'b1;
                    r.slot = j[3:0];
                end
            end
            if (found) begin
                res_valid[r.slot] = 1'b1;
                res_page[r.slot] = page;
                age_lim = 5'd16;
            end else begin
                r.slot = '0;
                for (int j = 1; j < m; j++) begin
                    if (res_rank[j] > res_rank[r.slot]) begin
                        r.slot = j[3:0];
                    end
                end
                r.ev = 1'b1;
                r.ev_page = res_page[r.slot];
                res_page[r.slot] = page;
                age_lim = {1'b0, res_rank[r.slot]};
            end
            if (fault_cnt != FAULT_MAX) begin
                fault_cnt = fault_cnt + 16'd1;
            end
        end
        for (int j = 0; j < 16; j++) begin
            if (j != r.slot && res_valid[j] && {1'b0, res_rank[j]} < age_lim &&
                res_rank[j] != 4'd15) begin
                res_rank[j] = res_rank[j] + 4'd1;
            end
        end
        res_rank[r.slot] = '0;
        r.faults = fault_cnt;
        if (last) begin
            clear_frames();
        end
        return r;
    endfunction

    task automatic issue_ref(input logic [15:0] page, input logic last);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= page;
        s_tlast <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        ref_outcomes.push_back(lru_reference(page, last));
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] n);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (ref_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= n;
        @(negedge i_clk);
        cfg_wen <= 1'b0;
        frames_cfg = n;
    endtask

    task automatic test_reset_defaults();
        issue_ref(16'h0000, 1'b0);
        issue_ref(16'hFFFF, 1'b0);
        issue_ref(16'h0000, 1'b0);
        issue_ref(16'h1234, 1'b1);
    endtask

    task automatic test_frame_limits();
        set_frames(5'd0);
        issue_ref(16'h0007, 1'b0);
        issue_ref(16'h0007, 1'b0);
        issue_ref(16'h0009, 1'b1);
        set_frames(5'd3);
        issue_ref(16'h0001, 1'b0);
        issue_ref(16'h0002, 1'b0);
        issue_ref(16'h0003, 1'b0);
        issue_ref(16'h0001, 1'b0);
        issue_ref(16'h0004, 1'b1);
        set_frames(5'd31);
        issue_ref(16'hA5A5, 1'b0);
        issue_ref(16'h5A5A, 1'b1);
    endtask

    task automatic test_duplicate_frames();
        set_frames(5'd16);
        issue_ref(16'h0A00, 1'b0);
        issue_ref(16'h0B00, 1'b0);
        issue_ref(16'h0C00, 1'b0);
        // shrink to one frame so the same page lands in frame 0 as well
        set_frames(5'd1);
        issue_ref(16'h0B00, 1'b0);
        set_frames(5'd17);
        issue_ref(16'h0B00, 1'b0);
        issue_ref(16'h0C00, 1'b1);
    endtask

    task automatic test_backpressure();
        logic [15:0] pool [8];
        set_frames(5'd16);
        for (int k = 0; k < 8; k++) begin
            pool[k] = 16'($urandom);
        end
        @(posedge i_clk);
        rx_hold = 400;
        for (int k = 0; k < 40; k++) begin
            issue_ref(pool[$urandom_range(0, 7)], k == 39);
        end
    endtask

    task automatic test_random_strings(input int total);
        logic [15:0]      pool [32];
        logic [15:0]      pg;
        logic [CFG_W-1:0] n;
        int               sent;
        int               len;
        int               m;
        sent = 0;
        while (sent < total) begin
            case ($urandom_range(0, 5))
                0: n = 5'd0;
                1: n = 5'd1;
                2: n = 5'd16;
                3: n = 5'd31;
                default: n = CFG_W'($urandom_range(0, 31));
            endcase
            if (total - sent <= 150) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            set_frames(n);
            m = (n == 0) ? 1 : ((n > 16) ? 16 : int'(n));
            for (int k = 0; k < 32; k++) begin
                pool[k] = 16'($urandom);
            end
            len = $urandom_range(60, 140);
            for (int k = 0; k < len && sent < total; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pg = 16'($urandom);
                end else begin
                    pg = pool[$urandom_range(0, m + 3)];
                end
                issue_ref(pg, $urandom_range(0, 47) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                rx_gap = $urandom_range(0, 4);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_lru_outcome want;
        t_lru_outcome got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                got = o_m_axis_tdata[37:0];
                if (ref_outcomes.size() == 0) begin
                    $display("%0t unexpected transfer: expected none, got %h", $time,
                             o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = ref_outcomes.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t hit: expected %0d, got %0d", $time, want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t slot: expected %0d, got %0d", $time, want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.ev !== want.ev) begin
                        $display("%0t evicted_valid: expected %0d, got %0d", $time, want.ev,
                                 got.ev);
                        mismatches++;
                    end
                    if (got.ev_page !== want.ev_page) begin
                        $display("%0t evicted_page: expected %h, got %h", $time, want.ev_page,
                                 got.ev_page);
                        mismatches++;
                    end
                    if (got.faults !== want.faults) begin
                        $display("%0t fault_total: expected %0d, got %0d", $time, want.faults,
                                 got.faults);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[39:38] !== 2'b00) begin
                        $display("%0t pad: expected 0, got %b", $time, o_m_axis_tdata[39:38]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        clear_frames();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_frame_limits();
        test_duplicate_frames();
        test_backpressure();
        test_random_strings(1100);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (ref_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: lru_page_replacement.f
hdl/lpr_pkg.sv
hdl/lpr_cell.sv
hdl/lru_page_replacement.sv
test/tb.sv
